FILE: hw/rtl/nntr_pkg.sv
`default_nettype none
package nntr_pkg;
  localparam int MaxCitiesDefault = 64;
  localparam int DistBitsDefault  = 16;
  localparam int CityBits         = 6;
  localparam int CountBits        = 7;
  localparam int RclBits          = 6;
  localparam int SeedBits         = 32;
  localparam int CfgIdxBits       = 2;
  localparam int CfgDataBits      = 32;
  localparam logic [CfgIdxBits-1:0] CfgCityCount  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgRclSize    = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgRandomSeed = 2'd2;
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdBuild = 1'b1;
  localparam logic [SeedBits-1:0] LfsrMask = 32'h80200003;

  typedef struct packed {
    logic                command;
    logic [CityBits-1:0] row;
    logic [CityBits-1:0] column;
    logic [15:0]         distance;
  } in_word_t;

  typedef struct packed {
    logic [CityBits-1:0] city;
    logic [CityBits-1:0] position;
    logic                last_city;
  } out_word_t;

  function automatic logic [SeedBits-1:0] lfsr_step(input logic [SeedBits-1:0] s);
    logic [SeedBits-1:0] r;
    r = s >> 1;
    if (s[0]) r = r ^ LfsrMask;
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/nntr_if.sv
`default_nettype none
interface nntr_in_if import nntr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nntr_out_if import nntr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/nearest_neighbor_tour_with_rcl.sv
`default_nettype none
// Nearest-neighbor tour builder with restricted candidate list.
// Input channel in_ch: command 0 stores distance[row][column] (no result;
// writes can follow back to back). Command 1 builds a tour from
// city 0 and emits one word per tour position on out_ch, with last_city set
// on the final one. in_ch is ready only while idle with out_ch empty.
// Config: cfg_we/cfg_idx/cfg_data write city_count, rcl_size, random_seed;
// write only while idle.
// Position 0 is valid the cycle after a build is taken.
// Each later step scans the n cities through the distance memory (one read
// per cycle, paused while a city is inserted) and inserts each unvisited one
// into a sorted list held in a second memory, one shifted entry per cycle;
// a random pick then reduces the next LFSR value modulo rcl_size.
// Shifts reach m*(m-1)/2 for m unvisited cities, fewer for mostly-sorted
// rows. The insertion shifts bound the rate.
// Reset returns to idle, clears the visited map and loads register defaults
// (64 cities, greedy, seed 1); memory contents stay undefined until written.
// A stalled receiver holds the output word; the build runs on to the next
// pick and waits there until the word is taken.
module nearest_neighbor_tour_with_rcl import nntr_pkg::*; #(
  parameter int MAX_CITIES = MaxCitiesDefault,
  parameter int DIST_BITS  = DistBitsDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx,
  input  wire logic [CfgDataBits-1:0] cfg_data,
  nntr_in_if.sink                     in_ch,
  nntr_out_if.source                  out_ch
);
  localparam int IdxBits  = $clog2(MAX_CITIES);
  localparam int CntBits  = IdxBits + 1;
  localparam int KeyBits  = DIST_BITS + IdxBits;
  localparam int AddrBits = 2 * IdxBits;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StShift = 3'd2;
  localparam logic [2:0] StPick  = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StMod   = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0]            state;
  logic [CountBits-1:0]  city_count;
  logic [RclBits-1:0]    rcl_size;
  logic [SeedBits-1:0]   random_seed;
  logic [SeedBits-1:0]   random_state;
  logic [MAX_CITIES-1:0] visited;
  logic [IdxBits-1:0]    cur;
  logic [CntBits-1:0]    n_eff;
  logic [CntBits-1:0]    pos;
  logic [CntBits-1:0]    scan;     // city whose distance is being requested
  logic                  rd_ok;    // dist read data valid this cycle
  logic [IdxBits-1:0]    rd_city;
  logic [CntBits-1:0]    count;
  logic [KeyBits-1:0]    key;
  logic [CntBits-1:0]    j;
  logic                  scan_done;
  logic [SeedBits-1:0]   rem;
  logic [5:0]            mod_step;
  out_word_t             out_word;
  logic                  out_valid;
  logic                  load_out;
  logic [IdxBits-1:0]    nxt;

  logic [DIST_BITS-1:0] d_rdata;
  logic [KeyBits-1:0]   r_rdata;
  logic                 r_we;
  logic [IdxBits-1:0]   r_waddr;
  logic [KeyBits-1:0]   r_wdata;
  logic [IdxBits-1:0]   r_raddr;
  logic [AddrBits-1:0]  d_raddr;
  logic [AddrBits-1:0]  d_waddr;
  logic                 d_we;
  logic                 wr_in_range;

  logic [CntBits-1:0] kept;
  logic [CntBits-1:0] rcl_ext;
  logic [CountBits-1:0] n_sat;

  assign wr_in_range = (32'(in_ch.data.row) < MAX_CITIES)
                    && (32'(in_ch.data.column) < MAX_CITIES);
  assign d_we    = in_ch.valid && in_ch.ready && (in_ch.data.command == CmdWrite)
                && wr_in_range;
  assign d_waddr = {in_ch.data.row[IdxBits-1:0], in_ch.data.column[IdxBits-1:0]};
  assign d_raddr = {cur, scan[IdxBits-1:0]};

  nntr_dist_mem #(.MAX_CITIES(MAX_CITIES), .DIST_BITS(DIST_BITS)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_waddr),
    .wdata(DIST_BITS'(in_ch.data.distance)),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  nntr_rank_mem #(.MAX_CITIES(MAX_CITIES), .KEY_BITS(KeyBits)) u_rank (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  always_comb begin
    if (city_count > CountBits'(MAX_CITIES)) n_sat = CountBits'(MAX_CITIES);
    else if (city_count == '0)               n_sat = CountBits'(1);
    else                                     n_sat = city_count;
  end

  assign rcl_ext = CntBits'(rcl_size) + CntBits'(1);
  assign kept    = (count > rcl_ext) ? rcl_ext : count;
  assign nxt     = (count == '0) ? '0 : r_rdata[IdxBits-1:0];

  // rank memory port control
  always_comb begin
    r_we    = 1'b0;
    r_waddr = j[IdxBits-1:0];
    r_wdata = key;
    r_raddr = '0;
    case (state)
      StShift: begin
        // r_rdata holds entry j-1 when shifting
        if (j != '0 && r_rdata > key) begin
          r_we    = 1'b1;
          r_wdata = r_rdata;
        end else begin
          r_we    = 1'b1;
          r_wdata = key;
        end
        r_raddr = (j >= CntBits'(2)) ? IdxBits'(j - CntBits'(2)) : '0;
      end
      StScan:  r_raddr = (count != '0) ? IdxBits'(count - CntBits'(1)) : '0;
      StPick:  r_raddr = '0;
      StMod:   r_raddr = rem[IdxBits-1:0];
      StRead:  r_raddr = rem[IdxBits-1:0];
      StEmit:  r_raddr = rem[IdxBits-1:0];
      default: r_raddr = '0;
    endcase
  end

  assign in_ch.ready  = (state == StIdle) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  assign load_out = ((state == StIdle) && in_ch.valid && in_ch.ready
                     && (in_ch.data.command == CmdBuild))
                 || ((state == StEmit) && (!out_valid || out_ch.ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= StIdle;
      city_count   <= CountBits'(64);
      rcl_size     <= '0;
      random_seed  <= SeedBits'(1);
      random_state <= SeedBits'(1);
      visited      <= '0;
      cur          <= '0;
      out_valid    <= 1'b0;
      rd_ok        <= 1'b0;
      scan_done    <= 1'b0;
      count        <= '0;
      pos          <= '0;
      scan         <= '0;
      n_eff        <= '0;
      j            <= '0;
      mod_step     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CfgCityCount:  city_count  <= cfg_data[CountBits-1:0];
          CfgRclSize:    rcl_size    <= cfg_data[RclBits-1:0];
          CfgRandomSeed: random_seed <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (in_ch.valid && in_ch.ready && in_ch.data.command == CmdBuild) begin
            random_state       <= random_seed;
            cur                <= '0;
            visited            <= MAX_CITIES'(1);
            n_eff              <= CntBits'(n_sat);
            pos                <= CntBits'(1);
            out_word.city      <= '0;
            out_word.position  <= '0;
            out_word.last_city <= (n_sat == CountBits'(1));
            if (n_sat != CountBits'(1)) begin
              state <= StScan;
              scan  <= '0;
              rd_ok <= 1'b0;
              count <= '0;
              scan_done <= 1'b0;
            end
          end
        end
        StScan: begin
          // issue read of scan, consume read of previous
          if (rd_ok && !visited[rd_city]) begin
            key       <= {d_rdata, rd_city};
            j         <= count;
            state     <= StShift;
            scan_done <= (scan >= n_eff);
            rd_ok     <= 1'b0;
          end else begin
            rd_ok <= (scan < n_eff);
            if (scan < n_eff) begin
              rd_city <= scan[IdxBits-1:0];
              scan    <= scan + CntBits'(1);
            end else if (!rd_ok && scan != '0) begin
              state <= StPick;
            end
          end
        end
        StShift: begin
          if (j != '0 && r_rdata > key) begin
            j <= j - CntBits'(1);
          end else begin
            count <= count + CntBits'(1);
            state <= scan_done ? StPick : StScan;
            rd_ok <= 1'b0;
          end
        end
        StPick: begin
          if (count == '0) begin
            state <= StRead;
            rem   <= '0;
          end else if (rcl_size != '0 && CntBits'(rcl_size) < kept) begin
            random_state <= lfsr_step(random_state);
            rem          <= lfsr_step(random_state);
            mod_step     <= 6'd0;
            state        <= StMod;
          end else begin
            rem   <= '0;
            state <= StRead;
          end
        end
        StMod: begin
          // restoring mod, one subtract of rcl_size<<s per cycle from bit 31 down
          if (rem >= (SeedBits'(rcl_size) << (5'd31 - mod_step[4:0]))
              && ((SeedBits'(rcl_size) << (5'd31 - mod_step[4:0]))
                  >> (5'd31 - mod_step[4:0])) == SeedBits'(rcl_size))
            rem <= rem - (SeedBits'(rcl_size) << (5'd31 - mod_step[4:0]));
          if (mod_step == 6'd31) state <= StRead;
          mod_step <= mod_step + 6'd1;
        end
        StRead: begin
          state <= StEmit;
        end
        StEmit: begin
          if (!out_valid || out_ch.ready) begin
            visited[nxt]       <= 1'b1;
            cur                <= nxt;
            out_word.city      <= CityBits'(nxt);
            out_word.position  <= CityBits'(pos);
            out_word.last_city <= (pos + CntBits'(1) == n_eff);
            pos                <= pos + CntBits'(1);
            if (pos + CntBits'(1) == n_eff) state <= StIdle;
            else begin
              state <= StScan;
              scan  <= '0;
              rd_ok <= 1'b0;
              count <= '0;
              scan_done <= 1'b0;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/nntr_dist_mem.sv
`default_nettype none
module nntr_dist_mem import nntr_pkg::*; #(
  parameter int MAX_CITIES = MaxCitiesDefault,
  parameter int DIST_BITS  = DistBitsDefault,
  localparam int AddrBits  = 2 * $clog2(MAX_CITIES)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AddrBits-1:0]  waddr,
  input  wire logic [DIST_BITS-1:0] wdata,
  input  wire logic [AddrBits-1:0]  raddr,
  output logic      [DIST_BITS-1:0] rdata
);
  // addressed as {row, column}, so the depth covers the full index space
  logic [DIST_BITS-1:0] mem [2**AddrBits];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/nntr_rank_mem.sv
`default_nettype none
// sorted candidate list, insertion by shifting one entry per cycle
module nntr_rank_mem import nntr_pkg::*; #(
  parameter int MAX_CITIES = MaxCitiesDefault,
  parameter int KEY_BITS   = 22,
  localparam int IdxBits   = $clog2(MAX_CITIES)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [IdxBits-1:0]  waddr,
  input  wire logic [KEY_BITS-1:0] wdata,
  input  wire logic [IdxBits-1:0]  raddr,
  output logic      [KEY_BITS-1:0] rdata
);
  logic [KEY_BITS-1:0] mem [MAX_CITIES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/sv/nntr_tour_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module nntr_tour_checker import nntr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx,
  input  wire logic [CfgDataBits-1:0] cfg_data,
  nntr_in_if                          in_mon,
  nntr_out_if                         out_mon,
  output int                          errors,
  output int                          outstanding
);

  logic [15:0]          dist_mem [0:4095];
  logic [CountBits-1:0] n_reg;
  logic [RclBits-1:0]   k_reg;
  logic [SeedBits-1:0]  seed_reg;
  out_word_t            tour_q [$];

  initial errors = 0;
  assign outstanding = tour_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic push_city(input int city, input int pos, input bit last);
    out_word_t w;
    w.city      = city[5:0];
    w.position  = pos[5:0];
    w.last_city = last;
    tour_q = {tour_q, w};
  endtask

  task automatic predict_tour();
    int n, p, c, cnt, kept, pos, j;
    logic [21:0] keys [0:63];
    logic [21:0] key;
    logic [63:0] seen;
    logic [5:0]  here;
    logic [5:0]  pick;
    logic [31:0] rng;
    n = (n_reg > 64) ? 64 : int'(n_reg);
    if (n < 1) n = 1;
    rng  = seed_reg;
    seen = 64'd1;
    here = '0;
    push_city(0, 0, n == 1);
    for (p = 1; p < n; p++) begin
      cnt = 0;
      for (c = 0; c < n; c++) begin
        if (!seen[c]) begin
          key = {dist_mem[{here, c[5:0]}], c[5:0]};
          j = cnt;
          while (j > 0 && keys[j-1] > key) begin
            keys[j] = keys[j-1];
            j--;
          end
          keys[j] = key;
          cnt++;
        end
      end
      kept = (cnt > int'(k_reg) + 1) ? int'(k_reg) + 1 : cnt;
      pos = 0;
      if (k_reg != 0 && int'(k_reg) < kept) begin
        rng = {1'b0, rng[31:1]} ^ (rng[0] ? LfsrMask : 32'd0);
        pos = int'(rng % k_reg);
      end
      pick = keys[pos][5:0];
      seen[pick] = 1'b1;
      here = pick;
      push_city(pick, p, p + 1 == n);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      n_reg    <= 7'd64;
      k_reg    <= '0;
      seed_reg <= 32'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CfgCityCount:  n_reg    <= cfg_data[CountBits-1:0];
          CfgRclSize:    k_reg    <= cfg_data[RclBits-1:0];
          CfgRandomSeed: seed_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.data.command == CmdWrite)
          dist_mem[{in_mon.data.row, in_mon.data.column}] = in_mon.data.distance;
        else
          predict_tour();
      end
      if (out_mon.valid && out_mon.ready) begin
        if (tour_q.size() == 0) begin
          report("unexpected word, city", out_mon.data.city, 0);
        end else begin
          out_word_t want;
          want = tour_q.pop_front();
          if (out_mon.data.city !== want.city)
            report("city", out_mon.data.city, want.city);
          if (out_mon.data.position !== want.position)
            report("position", out_mon.data.position, want.position);
          if (out_mon.data.last_city !== want.last_city)
            report("last_city", out_mon.data.last_city, want.last_city);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_nearest_neighbor_tour_with_rcl.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_nearest_neighbor_tour_with_rcl;
  import nntr_pkg::*;

  localparam int CycleLimit = 3000000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;
  int                     errors;
  int                     outstanding;
  int                     cycles;
  int                     sent;
  bit                     written [0:4095];
  bit                     tx_gaps;
  bit                     rx_gaps;
  bit                     hold_req;

  nntr_in_if  in_ch ();
  nntr_out_if out_ch ();

  nearest_neighbor_tour_with_rcl u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  nntr_tour_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_mon(in_ch), .out_mon(out_ch), .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] rand_dist();
    // small values make ties common
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_word(input logic cmd, input int r, input int c, input logic [15:0] d);
    int gap;
    in_word_t w;
    gap = tx_gaps ? $urandom_range(0, 13) : 0;
    w.command  = cmd;
    w.row      = r[5:0];
    w.column   = c[5:0];
    w.distance = d;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CmdWrite) written[{r[5:0], c[5:0]}] = 1'b1;
    sent++;
  endtask

  task automatic build_tour();
    send_word(CmdBuild, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
  endtask

  task automatic fill_matrix(input int n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (r != c && !written[r*64+c]) send_word(CmdWrite, r, c, rand_dist());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_cfg(input int n, input int k, input logic [31:0] seed);
    drain();
    write_reg(CfgCityCount, n);
    write_reg(CfgRclSize, k);
    write_reg(CfgRandomSeed, seed);
    cfg_we <= 1'b0;
  endtask

  // output side
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      g = rx_gaps ? $urandom_range(0, 13) : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int n, k, rounds;
    logic [31:0] seed;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_idx     <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    sent     = 0;
    tx_gaps  = 1'b1;
    rx_gaps  = 1'b1;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of distance, two cities
    set_cfg(2, 0, 1);
    send_word(CmdWrite, 0, 1, 16'h0000);
    send_word(CmdWrite, 1, 0, 16'hFFFF);
    build_tour();
    // all ties: lower index wins
    set_cfg(3, 0, 1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (r != c) send_word(CmdWrite, r, c, 16'd7);
    build_tour();
    // zero seed pins random pick to position 0
    set_cfg(4, 2, 0);
    fill_matrix(4);
    build_tour();
    // one-city tours
    set_cfg(0, 0, 1);
    build_tour();
    set_cfg(1, 3, 5);
    build_tour();
    // unknown register index is ignored
    drain();
    write_reg(2'd3, 32'h0000_0003);
    cfg_we <= 1'b0;
    build_tour();

    rounds = 0;
    while (sent < 140) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 10) : $urandom_range(2, 8);
      k = $urandom_range(0, n + 1);
      seed = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
      set_cfg(n, k, seed);
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      for (int i = $urandom_range(0, 4); i > 0; i--)
        send_word(CmdWrite, $urandom_range(0, 63), $urandom_range(0, 63), rand_dist());
      fill_matrix(n);
      if (rounds == 3) hold_req = 1'b1;
      build_tour();
      if (rounds == 3) begin
        for (int i = 0; i < 8; i++)
          send_word(CmdWrite, $urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_dist());
        fill_matrix(n);
        build_tour();
      end else if ($urandom_range(0, 2) == 0) begin
        build_tour();
      end
      rounds++;
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/nntr_pkg.sv
hw/rtl/nntr_if.sv
hw/rtl/nntr_dist_mem.sv
hw/rtl/nntr_rank_mem.sv
hw/rtl/nearest_neighbor_tour_with_rcl.sv
tb/sv/nntr_tour_checker.sv
tb/sv/tb_nearest_neighbor_tour_with_rcl.sv
